// ===== hdl/rounded_rect_alpha_fill_macros.svh =====
// assertion helpers, sampled on clk and disabled during rst
`ifndef ROUNDED_RECT_ALPHA_FILL_MACROS_SVH
`define ROUNDED_RECT_ALPHA_FILL_MACROS_SVH

// same-cycle implication
`define RRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrf: same-cycle check failed");

// next-cycle implication
`define RRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("rrf: next-cycle check failed");

`endif

// ===== hdl/rrf_pkg.sv =====
package rrf_pkg;

  localparam int PIX_W          = 13;
  localparam int COORD_BITS_DEF = 13;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;

  localparam logic [23:0] RB_MASK       = 24'hFF00FF;
  localparam logic [23:0] G_MASK        = 24'h00FF00;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'd255;
  localparam logic [7:0]  ALPHA_CLEAR   = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT     = 4'd0,
    REG_RECT_TOP      = 4'd1,
    REG_RECT_WIDTH    = 4'd2,
    REG_RECT_HEIGHT   = 4'd3,
    REG_CORNER_RADIUS = 4'd4,
    REG_FILL_COLOR    = 4'd5,
    REG_SCREEN_WIDTH  = 4'd6,
    REG_SCREEN_HEIGHT = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] rect_left;
    logic [11:0] rect_top;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [11:0] corner_radius;
    logic [31:0] fill_color;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic [31:0]      background;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] new_pixel;
  } out_item_t;

endpackage

// ===== hdl/rrf_cfg_regs.sv =====
module rrf_cfg_regs
  import rrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RECT_LEFT:     cfg.rect_left     <= wr_data[11:0];
        REG_RECT_TOP:      cfg.rect_top      <= wr_data[11:0];
        REG_RECT_WIDTH:    cfg.rect_width    <= wr_data[12:0];
        REG_RECT_HEIGHT:   cfg.rect_height   <= wr_data[12:0];
        REG_CORNER_RADIUS: cfg.corner_radius <= wr_data[11:0];
        REG_FILL_COLOR:    cfg.fill_color    <= wr_data[31:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= wr_data[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= wr_data[12:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rrf_cover.sv =====
module rrf_cover
  import rrf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  cfg_t             cfg,
  input  logic [PIX_W-1:0] pixel_col,
  input  logic [PIX_W-1:0] pixel_row,
  output logic             hit
);

  localparam logic [PIX_W-1:0] CMASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

  // depth into a rounded corner along one axis, zero on the straight part
  function automatic logic [11:0] corner_off(logic [12:0] p, logic [11:0] start,
                                             logic [12:0] len, logic [11:0] rad);
    logic [13:0]        lo;
    logic signed [14:0] hi;
    logic signed [14:0] ps;
    logic [14:0]        d;
    lo = {2'b0, start} + {2'b0, rad};
    hi = $signed({3'b0, start}) + $signed({2'b0, len}) - $signed({3'b0, rad});
    ps = $signed({2'b0, p});
    if ({1'b0, p} < lo) begin
      d = {1'b0, lo - {1'b0, p}};
    end else if (ps >= hi) begin
      d = 15'(ps - hi + 15'sd1);
    end else begin
      d = '0;
    end
    return d[11:0];
  endfunction

  logic [PIX_W-1:0] col, row;
  logic [13:0]      x_end, y_end;
  logic             in_rect, on_screen, corner_ok, alpha_on;
  logic [11:0]      dx, dy;
  logic [23:0]      dxx, dyy, rr;
  logic [24:0]      dsq;

  always_comb begin
    col   = pixel_col & CMASK;
    row   = pixel_row & CMASK;
    x_end = {2'b0, cfg.rect_left} + {1'b0, cfg.rect_width};
    y_end = {2'b0, cfg.rect_top} + {1'b0, cfg.rect_height};
    in_rect = ({1'b0, col} >= {2'b0, cfg.rect_left}) && ({1'b0, col} < x_end) &&
              ({1'b0, row} >= {2'b0, cfg.rect_top}) && ({1'b0, row} < y_end);

    // offsets are only meaningful inside the rectangle, where they never exceed the radius
    dx   = corner_off(col, cfg.rect_left, cfg.rect_width, cfg.corner_radius);
    dy   = corner_off(row, cfg.rect_top, cfg.rect_height, cfg.corner_radius);
    dxx  = 24'(dx) * 24'(dx);
    dyy  = 24'(dy) * 24'(dy);
    rr   = 24'(cfg.corner_radius) * 24'(cfg.corner_radius);
    dsq  = {1'b0, dxx} + {1'b0, dyy};
    corner_ok = (dx == '0) || (dy == '0) || (dsq <= {1'b0, rr});

    on_screen = (col < cfg.screen_width) && (row < cfg.screen_height);
    alpha_on  = cfg.fill_color[31:24] != ALPHA_CLEAR;
    hit = in_rect && corner_ok && on_screen && alpha_on;
  end

endmodule

// ===== hdl/rrf_blend.sv =====
module rrf_blend
  import rrf_pkg::*;
(
  input  logic [31:0] fill_color,
  input  logic [31:0] background,
  output logic [31:0] pixel
);

  // exact floor(x / 255): shift-add estimate is low by at most one
  function automatic logic [24:0] div255(logic [31:0] x);
    logic [32:0] s;
    logic [24:0] q0;
    logic [32:0] prod;
    logic [32:0] rem;
    s    = {1'b0, x} + {9'b0, x[31:8]} + {17'b0, x[31:16]} + {25'b0, x[31:24]};
    q0   = s[32:8];
    prod = {q0, 8'b0} - {8'b0, q0};
    rem  = {1'b0, x} - prod;
    return q0 + {24'b0, (rem >= 33'd255)};
  endfunction

  logic [7:0]  a, na;
  logic [31:0] rb_fa, rb_bn, rb_sum, g_fa, g_bn, g_sum;
  logic [24:0] rb_q, g_q;

  always_comb begin
    a      = fill_color[31:24];
    na     = ALPHA_OPAQUE - a;
    rb_fa  = 32'(fill_color[23:0] & RB_MASK) * 32'(a);
    rb_bn  = 32'(background[23:0] & RB_MASK) * 32'(na);
    g_fa   = 32'(fill_color[23:0] & G_MASK) * 32'(a);
    g_bn   = 32'(background[23:0] & G_MASK) * 32'(na);
    rb_sum = rb_fa + rb_bn;
    g_sum  = g_fa + g_bn;
    rb_q   = div255(rb_sum);
    g_q    = div255(g_sum);
    if (a == ALPHA_OPAQUE) begin
      pixel = fill_color;
    end else begin
      pixel = {8'h00, (rb_q[23:0] & RB_MASK) | (g_q[23:0] & G_MASK)};
    end
  end

endmodule

// ===== hdl/rounded_rect_alpha_fill.sv =====
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+--------------------------------
// item    | in        | start & !busy             | pixel_col, pixel_row, background
// result  | out       | done, one cycle, no stall | write_enable, new_pixel
// config  | in        | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// one item per cycle; a result strobes on done after the input and result registers
// the path is input register, coverage test and blend side by side, result register
// rst is synchronous; busy and !cfg_ready only during rst, config registers read zero after
// the result side cannot stall, so items are never held off once out of reset
`include "rounded_rect_alpha_fill_macros.svh"

module rounded_rect_alpha_fill
  import rrf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      in_valid;
  in_item_t  in_q;
  logic      hit;
  logic [31:0] blend_pix;
  out_item_t result_next;

  assign busy      = rst;
  assign cfg_ready = !rst;

  rrf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_q <= item;
    end
  end

  rrf_cover #(
    .COORD_BITS (COORD_BITS)
  ) u_cover (
    .cfg       (cfg),
    .pixel_col (in_q.pixel_col),
    .pixel_row (in_q.pixel_row),
    .hit       (hit)
  );

  rrf_blend u_blend (
    .fill_color (cfg.fill_color),
    .background (in_q.background),
    .pixel      (blend_pix)
  );

  always_comb begin
    result_next.write_enable = hit;
    result_next.new_pixel    = hit ? blend_pix : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  `RRF_ASSERT_NEXT(a_item_latency, start && !busy, ##1 done)
  `RRF_ASSERT_NOW(a_idle_zero, done && !result.write_enable, result.new_pixel == '0)
  `RRF_ASSERT_NOW(a_clear_alpha, done && ($past(cfg.fill_color[31:24]) == ALPHA_CLEAR),
                  !result.write_enable)
  `RRF_ASSERT_NOW(a_opaque_copy,
                  done && result.write_enable &&
                  ($past(cfg.fill_color[31:24]) == ALPHA_OPAQUE),
                  result.new_pixel == $past(cfg.fill_color))

endmodule

// ===== tb/sv/tb_rounded_rect_alpha_fill.sv =====
module tb_rounded_rect_alpha_fill;
  import rrf_pkg::*;

  localparam int LATENCY      = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 90;
  localparam int IDLE_LEVELS [3] = '{0, 88, 26};

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item = '0;
  logic                  done;
  out_item_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t   pixel_q [$];
  out_item_t  shade_q [$];
  reg_write_t write_q [$];
  cfg_t       shader_regs = '0;
  int         idle_pct = 0;
  int         errors = 0;
  int         cycles = 0;

  rounded_rect_alpha_fill dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // depth into a rounded corner along one axis, zero on the straight part
  function automatic longint corner_depth(longint p, longint s, longint len, longint rad);
    if (p < s + rad) return s + rad - p;
    if (p >= s + len - rad) return p - (s + len - rad) + 1;
    return 0;
  endfunction

  function automatic out_item_t shade_pixel(cfg_t c, in_item_t px);
    longint col, row, x, y, w, h, r, dx, dy;
    longint unsigned a, na, rb, g, div;
    logic [7:0] alpha;
    logic covered;
    out_item_t res;
    col = longint'(px.pixel_col) & ((longint'(1) << COORD_BITS_DEF) - 1);
    row = longint'(px.pixel_row) & ((longint'(1) << COORD_BITS_DEF) - 1);
    x = longint'(c.rect_left);
    y = longint'(c.rect_top);
    w = longint'(c.rect_width);
    h = longint'(c.rect_height);
    r = longint'(c.corner_radius);
    alpha = c.fill_color[31:24];
    covered = !(col < x || col >= x + w || row < y || row >= y + h);
    if (covered) begin
      dx = corner_depth(col, x, w, r);
      dy = corner_depth(row, y, h, r);
      if (dx != 0 && dy != 0 && dx * dx + dy * dy > r * r) covered = 1'b0;
    end
    if (col >= longint'(c.screen_width) || row >= longint'(c.screen_height)) covered = 1'b0;
    if (alpha == ALPHA_CLEAR) covered = 1'b0;
    res = '0;
    if (covered) begin
      res.write_enable = 1'b1;
      if (alpha == ALPHA_OPAQUE) begin
        res.new_pixel = c.fill_color;
      end else begin
        div = longint'(ALPHA_OPAQUE);
        a = longint'(alpha);
        na = div - a;
        // packed lanes: carries may cross from blue into red before the mask
        rb = (longint'(c.fill_color[23:0] & RB_MASK) * a +
              longint'(px.background[23:0] & RB_MASK) * na) / div;
        g = (longint'(c.fill_color[23:0] & G_MASK) * a +
             longint'(px.background[23:0] & G_MASK) * na) / div;
        res.new_pixel = {8'h00, (rb[23:0] & RB_MASK) | (g[23:0] & G_MASK)};
      end
    end
    return res;
  endfunction

  function automatic in_item_t pixel(logic [31:0] col, logic [31:0] row, logic [31:0] bg);
    in_item_t px;
    px.pixel_col = col[PIX_W-1:0];
    px.pixel_row = row[PIX_W-1:0];
    px.background = bg;
    return px;
  endfunction

  // keep the low bits, random garbage above the register width
  function automatic logic [31:0] noisy(logic [31:0] v, int bits);
    logic [31:0] keep;
    keep = (32'd1 << bits) - 1;
    return (v & keep) | ($urandom & ~keep);
  endfunction

  always @(negedge clk) begin
    if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      item <= pixel_q[0];
    end else begin
      start <= 1'b0;
    end
    if (write_q.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= write_q[0].idx;
      cfg_data <= write_q[0].data;
    end else begin
      cfg_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst) begin
      if (done) begin
        if (shade_q.size() == 0) begin
          $display("%0t: result with nothing expected, write_enable %0b new_pixel %08h",
                   $time, result.write_enable, result.new_pixel);
          errors++;
        end else begin
          want = shade_q.pop_front();
          if (result.write_enable !== want.write_enable) begin
            $display("%0t: write_enable expected %0b actual %0b",
                     $time, want.write_enable, result.write_enable);
            errors++;
          end
          if (result.new_pixel !== want.new_pixel) begin
            $display("%0t: new_pixel expected %08h actual %08h",
                     $time, want.new_pixel, result.new_pixel);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        shade_q.push_back(shade_pixel(shader_regs, item));
        void'(pixel_q.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RECT_LEFT:     shader_regs.rect_left = cfg_data[11:0];
          REG_RECT_TOP:      shader_regs.rect_top = cfg_data[11:0];
          REG_RECT_WIDTH:    shader_regs.rect_width = cfg_data[12:0];
          REG_RECT_HEIGHT:   shader_regs.rect_height = cfg_data[12:0];
          REG_CORNER_RADIUS: shader_regs.corner_radius = cfg_data[11:0];
          REG_FILL_COLOR:    shader_regs.fill_color = cfg_data;
          REG_SCREEN_WIDTH:  shader_regs.screen_width = cfg_data[12:0];
          REG_SCREEN_HEIGHT: shader_regs.screen_height = cfg_data[12:0];
          default: ;
        endcase
        void'(write_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // wait for all queues to drain, then let the pipeline empty
  task automatic settle();
    do @(negedge clk); while (pixel_q.size() != 0 || shade_q.size() != 0 ||
                              write_q.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic program_config(logic [31:0] left, logic [31:0] top, logic [31:0] wd,
                                logic [31:0] ht, logic [31:0] rad, logic [31:0] fill,
                                logic [31:0] sw, logic [31:0] sh);
    write_q.push_back('{REG_RECT_LEFT, noisy(left, 12)});
    write_q.push_back('{REG_RECT_TOP, noisy(top, 12)});
    write_q.push_back('{REG_RECT_WIDTH, noisy(wd, 13)});
    write_q.push_back('{REG_RECT_HEIGHT, noisy(ht, 13)});
    write_q.push_back('{REG_CORNER_RADIUS, noisy(rad, 12)});
    write_q.push_back('{REG_FILL_COLOR, fill});
    write_q.push_back('{REG_SCREEN_WIDTH, noisy(sw, 13)});
    write_q.push_back('{REG_SCREEN_HEIGHT, noisy(sh, 13)});
    // an index past the register list must change nothing
    write_q.push_back('{CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                                 int'(REG_SCREEN_HEIGHT) + 1)), $urandom});
    settle();
  endtask

  // mostly pixels around the rectangle and its corners, some anywhere
  task automatic queue_pixels(int n);
    int x0, y0, w0, h0, r0, pick;
    logic [31:0] col, row;
    x0 = shader_regs.rect_left;
    y0 = shader_regs.rect_top;
    w0 = shader_regs.rect_width;
    h0 = shader_regs.rect_height;
    r0 = shader_regs.corner_radius;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        col = $urandom;
        row = $urandom;
      end else if (pick <= 4) begin
        col = $urandom_range(1) ? x0 + $urandom_range(r0 + 1) : x0 + w0 - 1 - $urandom_range(r0 + 1);
        row = $urandom_range(1) ? y0 + $urandom_range(r0 + 1) : y0 + h0 - 1 - $urandom_range(r0 + 1);
      end else begin
        col = x0 - 3 + $urandom_range(w0 + 5);
        row = y0 - 3 + $urandom_range(h0 + 5);
      end
      pixel_q.push_back(pixel(col, row, $urandom));
    end
    settle();
  endtask

  initial begin : stimulus
    int wd, ht, rad, lf, tp, sw, sh;
    logic [31:0] fill;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // registers straight out of reset: empty rectangle, nothing written
    queue_pixels(4);

    // half-transparent rounded rectangle
    program_config(100, 50, 40, 30, 10, 32'h80336699, 4096, 4096);
    pixel_q.push_back(pixel(100, 50, $urandom));
    pixel_q.push_back(pixel(103, 53, $urandom));
    pixel_q.push_back(pixel(109, 50, $urandom));
    pixel_q.push_back(pixel(110, 50, $urandom));
    pixel_q.push_back(pixel(139, 79, $urandom));
    pixel_q.push_back(pixel(120, 65, $urandom));
    pixel_q.push_back(pixel(99, 65, $urandom));
    pixel_q.push_back(pixel(140, 65, $urandom));
    pixel_q.push_back(pixel(120, 49, $urandom));
    pixel_q.push_back(pixel(120, 80, $urandom));
    pixel_q.push_back(pixel(100, 60, $urandom));
    pixel_q.push_back(pixel(8191, 8191, 32'hFFFFFFFF));
    pixel_q.push_back(pixel(121, 66, 32'h00000000));
    pixel_q.push_back(pixel(122, 66, 32'hFFFFFFFF));
    settle();
    // opaque fill, screen edge cuts through the rectangle
    program_config(100, 50, 40, 30, 10, 32'hFFC0FFEE, 130, 70);
    pixel_q.push_back(pixel(120, 65, $urandom));
    pixel_q.push_back(pixel(135, 65, $urandom));
    pixel_q.push_back(pixel(120, 75, $urandom));
    settle();
    // fully transparent fill
    program_config(100, 50, 40, 30, 10, 32'h00FFFFFF, 4096, 4096);
    pixel_q.push_back(pixel(120, 65, $urandom));
    settle();
    // zero screen width
    program_config(100, 50, 40, 30, 0, 32'hFF123456, 0, 4096);
    pixel_q.push_back(pixel(120, 65, $urandom));
    settle();
    // radius larger than half of each side
    program_config(100, 50, 10, 10, 8, 32'h40A0B0C0, 4096, 4096);
    pixel_q.push_back(pixel(104, 54, $urandom));
    pixel_q.push_back(pixel(100, 50, $urandom));
    pixel_q.push_back(pixel(109, 59, $urandom));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = IDLE_LEVELS[p % 3];
      if (p == 0) begin
        program_config(4095, 4095, 4096, 4096, 2048, 32'hFFFFFFFF, 8191, 8191);
      end else if (p == 1) begin
        program_config(0, 0, 1, 1, 0, 32'hFE000000, 4096, 4096);
      end else begin
        lf = $urandom_range(4095);
        tp = $urandom_range(4095);
        wd = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 80);
        ht = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 80);
        rad = ($urandom_range(7) == 0) ? $urandom_range(4095)
                                       : $urandom_range(((wd < ht) ? wd : ht) / 2);
        fill = $urandom;
        case ($urandom_range(4))
          0: fill[31:24] = ALPHA_CLEAR;
          1: fill[31:24] = ALPHA_OPAQUE;
          default: ;
        endcase
        sw = 4096;
        sh = 4096;
        case ($urandom_range(3))
          0: begin
            sw = $urandom_range(8191);
            sh = $urandom_range(8191);
          end
          1: begin
            sw = lf + $urandom_range(wd);
            sh = tp + $urandom_range(ht);
          end
          default: ;
        endcase
        program_config(lf, tp, wd, ht, rad, fill, sw, sh);
      end
      queue_pixels(PHASE_ITEMS);
    end

    if (errors == 0 && shade_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
